[sv/sipq_pkg.sv]
// Shared types and constants for the sorted insert priority queue.
`timescale 1ns / 1ps

package sipq_pkg;

	localparam int DATA_W      = 32;
	localparam int POS_W       = 4;
	localparam int READOUT_MAX = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CMP,
		ST_INS,
		ST_READ
	} seq_state_t;

	// side information that travels with each word read out of the store
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             ovf;
		logic [POS_W-1:0] pos;
	} rd_meta_t;

endpackage

[sv/sorted_insert_priority_queue.sv]
// Top level of the sorted insert priority queue.
// Holds up to DEPTH signed words in descending order; a new word goes in
// after every stored entry that is greater or equal, and when the store is
// full the smallest entry (possibly the new word) is dropped. A word is taken
// when start is high and busy is low. The insert walks down from the tail,
// one entry at a time (store read, then compare and write), since the
// store has a single read port; an empty store or an insert at the head
// ends with a separate write to the head. The ordered contents then stream
// out one word per cycle on strobe, largest first, at most sixteen, with
// is_last on the final one and overflowed on all of them if an entry was
// dropped. The receiver cannot stall: each result is valid for exactly the
// one cycle in which strobe is high. The store needs no clearing after
// reset; the entry count starts at zero.
`timescale 1ns / 1ps

module sorted_insert_priority_queue
	import sipq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] new_value,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] entry_value,
	output logic [POS_W-1:0]         entry_position,
	output logic                     is_last,
	output logic                     overflowed
);

	localparam int AW = $clog2(DEPTH);
	localparam int IW = $clog2(DEPTH + 1);

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic signed [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic signed [DATA_W-1:0] ram_rdata;
	rd_meta_t                 meta_s1;

	sipq_seq #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.IW   (IW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.new_value(new_value),
		.busy     (busy),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.meta_s1  (meta_s1)
	);

	sipq_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read data and its side information leave the same register stage
	assign strobe         = meta_s1.valid;
	assign entry_value    = ram_rdata;
	assign entry_position = meta_s1.pos;
	assign is_last        = meta_s1.last;
	assign overflowed     = meta_s1.ovf;

endmodule

[sv/sipq_ram.sv]
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module sipq_ram
	import sipq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic signed [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[sv/sipq_seq.sv]
// Sequencer: insertion walk with the shared signed comparator, then readout.
`timescale 1ns / 1ps

module sipq_seq
	import sipq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int IW    = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] new_value,
	output logic                     busy,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic signed [DATA_W-1:0] ram_wdata,
	output logic [AW-1:0]            ram_raddr,
	input  logic signed [DATA_W-1:0] ram_rdata,
	output rd_meta_t                 meta_s1
);

	localparam int RD_MAX = (DEPTH < READOUT_MAX) ? DEPTH : READOUT_MAX;

	seq_state_t               state_q, state_d;
	logic signed [DATA_W-1:0] val_q;
	logic [IW-1:0]            i_q;
	logic [IW-1:0]            i_dec;
	logic [IW-1:0]            count_q;
	logic [IW-1:0]            n_last;
	logic [AW-1:0]            k_q;
	logic                     full_q;
	logic                     less;
	logic                     k_last;

	// the one compare unit, reused on every step of the walk
	assign less  = ram_rdata < val_q;
	assign i_dec = i_q - IW'(1);

	assign n_last = (count_q < IW'(RD_MAX)) ? (count_q - IW'(1)) : IW'(RD_MAX - 1);
	assign k_last = (IW'(k_q) == n_last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (count_q == '0) ? ST_INS : ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_CMP;
			ST_CMP: begin
				if (less) begin
					state_d = (i_dec == '0) ? ST_INS : ST_FETCH;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_INS:  state_d = ST_READ;
			ST_READ: begin
				if (k_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy      = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = val_q;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_FETCH: ram_raddr = i_dec[AW-1:0];
			ST_CMP: begin
				// slot DEPTH is the one that falls off a full store
				ram_we    = (i_q != IW'(DEPTH));
				ram_waddr = i_q[AW-1:0];
				ram_wdata = less ? ram_rdata : val_q;
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
			end
			ST_READ:  ram_raddr = k_q;
			default:  busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			i_q     <= '0;
			k_q     <= '0;
			full_q  <= 1'b0;
			meta_s1 <= '0;
		end else begin
			state_q       <= state_d;
			meta_s1.valid <= (state_q == ST_READ);
			meta_s1.last  <= k_last;
			meta_s1.ovf   <= full_q;
			meta_s1.pos   <= POS_W'(k_q);
			if (state_q == ST_IDLE && start) begin
				i_q    <= count_q;
				k_q    <= '0;
				full_q <= (count_q == IW'(DEPTH));
				if (count_q != IW'(DEPTH)) begin
					count_q <= count_q + IW'(1);
				end
			end
			if (state_q == ST_CMP && less) begin
				i_q <= i_dec;
			end
			if (state_q == ST_READ) begin
				k_q <= k_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			val_q <= new_value;
		end
	end

endmodule

[sv/sipq_checker.sv]
// Port-level checks for the sorted insert priority queue, bound to the top.
`timescale 1ns / 1ps

module sipq_checker
	import sipq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic [POS_W-1:0]  entry_position,
	input logic              is_last,
	input logic              overflowed
);

	// an accepted word always keeps the block occupied for a while
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepting a word");

	// a readout starts at the head of the queue
	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> entry_position == '0)
		else $error("readout does not start at position zero");

	// readout words come back to back in position order
	a_next_pos: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_last |=> strobe && entry_position == $past(entry_position) + 1'b1)
		else $error("readout gap or position out of order");

	// overflow is a property of the whole readout
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_last |=> overflowed == $past(overflowed))
		else $error("overflowed changed within a readout");

	// mid-readout the block cannot take another word
	a_busy_readout: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_last |-> busy)
		else $error("not busy while a readout is in progress");

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.strobe        (strobe),
	.entry_position(entry_position),
	.is_last       (is_last),
	.overflowed    (overflowed)
);
